### rtl/core/sgm_pca_pkg.sv
// Package for the left-to-right SGM path cost aggregation block.
// Field widths, register indexes, reset values and the DP cell input struct.
// No dependencies.
package sgm_pca_pkg;

  localparam int COST_W  = 6;
  localparam int PATH_W  = 8;
  localparam int DISP_W  = 6;
  localparam int PEN_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SMALL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_LARGE = 1'd1;

  localparam logic [PEN_W-1:0] PENALTY_SMALL_RESET = 7'd10;
  localparam logic [PEN_W-1:0] PENALTY_LARGE_RESET = 7'd60;

  localparam logic [PATH_W-1:0] PATH_MAX = 8'hFF;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              first_column;
    logic [PATH_W-1:0] old_here;
    logic [PATH_W-1:0] upper;
    logic [PATH_W-1:0] held_lower;
    logic [PATH_W-1:0] prev_min;
    logic [PEN_W-1:0]  penalty_small;
    logic [PEN_W-1:0]  penalty_large;
    logic              at_lowest;
    logic              at_highest;
  } dp_in_t;

endpackage

### rtl/core/sgm_pca_if.sv
// Valid/ready channel interfaces for the SGM path cost aggregation block.
// Depends on sgm_pca_pkg for field widths.
interface sgm_pca_in_if;
  logic                           valid;
  logic                           ready;
  logic [sgm_pca_pkg::COST_W-1:0] cost;
  logic                           first_column;

  modport source (output valid, output cost, output first_column, input ready);
  modport sink   (input valid, input cost, input first_column, output ready);
endinterface

interface sgm_pca_out_if;
  logic                           valid;
  logic                           ready;
  logic [sgm_pca_pkg::PATH_W-1:0] path_cost;
  logic [sgm_pca_pkg::DISP_W-1:0] disparity;
  logic                           last_of_pixel;
  logic [sgm_pca_pkg::PATH_W-1:0] pixel_min;

  modport source (output valid, output path_cost, output disparity, output last_of_pixel,
                  output pixel_min, input ready);
  modport sink   (input valid, input path_cost, input disparity, input last_of_pixel,
                  input pixel_min, output ready);
endinterface

### rtl/core/sgm_pca_cell.sv
// One cell of the previous-pixel cost line: holds one path cost and
// passes it to its lower neighbour on each shift. Depends on sgm_pca_pkg.
module sgm_pca_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift,
  input  logic [sgm_pca_pkg::PATH_W-1:0] din,
  output logic [sgm_pca_pkg::PATH_W-1:0] dout
);

  logic [sgm_pca_pkg::PATH_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

### rtl/core/sgm_pca_dp.sv
// DP step of the path aggregation: minimum over the neighbour terms,
// normalised by the previous pixel minimum. Depends on sgm_pca_pkg.
module sgm_pca_dp (
  input  sgm_pca_pkg::dp_in_t             dp_in,
  output logic [sgm_pca_pkg::PATH_W-1:0]  path
);

  localparam int SUM_W = sgm_pca_pkg::PATH_W + 1;

  logic [SUM_W-1:0] prev_min_x;
  logic [SUM_W-1:0] term_large;
  logic [SUM_W-1:0] term_lower;
  logic [SUM_W-1:0] term_upper;
  logic [SUM_W-1:0] best;
  logic [SUM_W-1:0] diff;
  logic [SUM_W-1:0] total;

  always_comb begin
    prev_min_x = SUM_W'(dp_in.prev_min);
    term_large = prev_min_x + SUM_W'(dp_in.penalty_large);
    term_lower = SUM_W'(dp_in.held_lower) + SUM_W'(dp_in.penalty_small);
    term_upper = SUM_W'(dp_in.upper) + SUM_W'(dp_in.penalty_small);

    best = SUM_W'(dp_in.old_here);
    if (term_large < best) begin
      best = term_large;
    end
    if (!dp_in.at_lowest && term_lower < best) begin
      best = term_lower;
    end
    if (!dp_in.at_highest && term_upper < best) begin
      best = term_upper;
    end

    // history can be inconsistent after reset: clamp at zero
    if (best < prev_min_x) begin
      diff = '0;
    end else begin
      diff = best - prev_min_x;
    end
    total = SUM_W'(dp_in.cost) + diff;

    if (dp_in.first_column) begin
      path = sgm_pca_pkg::PATH_W'(dp_in.cost);
    end else if (total > SUM_W'(sgm_pca_pkg::PATH_MAX)) begin
      path = sgm_pca_pkg::PATH_MAX;
    end else begin
      path = total[sgm_pca_pkg::PATH_W-1:0];
    end
  end

endmodule

### rtl/core/sgm_path_cost_aggregation.sv
// Top level of the left-to-right SGM path cost aggregation block.
// Uses sgm_pca_pkg, sgm_pca_in_if/sgm_pca_out_if, sgm_pca_cell and sgm_pca_dp.
//
//   channel   direction  transaction payload
//   in_ch     sink       cost, first_column
//   out_ch    source     path_cost, disparity, last_of_pixel, pixel_min
//   cfg_*     write      cfg_index selects penalty_small / penalty_large
//
// One transaction per cycle unless stalled; result next cycle in the output
// register. The line of DISPARITIES cells rotates by one per transaction, so
// cell 0 always holds the previous pixel's cost at the current disparity.
// Synchronous reset zeroes the cell line, minima and counter.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
module sgm_path_cost_aggregation #(
  parameter int DISPARITIES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sgm_pca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgm_pca_pkg::CFG_DATA_W-1:0] cfg_data,
  sgm_pca_in_if.sink                         in_ch,
  sgm_pca_out_if.source                      out_ch
);

  localparam int CNT_W = (DISPARITIES > 1) ? $clog2(DISPARITIES) : 1;
  localparam logic [CNT_W-1:0] LAST_DISP = CNT_W'(DISPARITIES - 1);

  logic [sgm_pca_pkg::PEN_W-1:0]  penalty_small;
  logic [sgm_pca_pkg::PEN_W-1:0]  penalty_large;
  logic [CNT_W-1:0]               disp_count;
  logic [sgm_pca_pkg::PATH_W-1:0] prev_min;
  logic [sgm_pca_pkg::PATH_W-1:0] running_min;
  logic [sgm_pca_pkg::PATH_W-1:0] held_lower;
  logic                           out_valid;

  logic                           accept;
  logic                           at_lowest;
  logic                           at_highest;
  logic [sgm_pca_pkg::PATH_W-1:0] path;
  logic [sgm_pca_pkg::PATH_W-1:0] running_min_next;
  logic [sgm_pca_pkg::PATH_W-1:0] cell_q [DISPARITIES];
  sgm_pca_pkg::dp_in_t            dp_in;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign at_lowest   = (disp_count == '0);
  assign at_highest  = (disp_count == LAST_DISP);

  // cost line: cell k holds the previous pixel's cost at d+k < DISPARITIES
  for (genvar k = 0; k < DISPARITIES; k++) begin : g_cell
    logic [sgm_pca_pkg::PATH_W-1:0] din;
    if (k == DISPARITIES - 1) begin : g_tail
      assign din = path;
    end else begin : g_body
      assign din = cell_q[k+1];
    end
    sgm_pca_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .din   (din),
      .dout  (cell_q[k])
    );
  end

  always_comb begin
    dp_in.cost          = in_ch.cost;
    dp_in.first_column  = in_ch.first_column;
    dp_in.old_here      = cell_q[0];
    dp_in.upper         = cell_q[1];
    dp_in.held_lower    = held_lower;
    dp_in.prev_min      = prev_min;
    dp_in.penalty_small = penalty_small;
    dp_in.penalty_large = penalty_large;
    dp_in.at_lowest     = at_lowest;
    dp_in.at_highest    = at_highest;
  end

  sgm_pca_dp u_dp (
    .dp_in (dp_in),
    .path  (path)
  );

  assign running_min_next = (at_lowest || path < running_min) ? path : running_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_small <= sgm_pca_pkg::PENALTY_SMALL_RESET;
      penalty_large <= sgm_pca_pkg::PENALTY_LARGE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sgm_pca_pkg::REG_PENALTY_SMALL: penalty_small <= cfg_data;
        sgm_pca_pkg::REG_PENALTY_LARGE: penalty_large <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_count  <= '0;
      prev_min    <= '0;
      running_min <= '0;
      held_lower  <= '0;
    end else if (accept) begin
      held_lower  <= cell_q[0];
      running_min <= running_min_next;
      if (at_highest) begin
        prev_min   <= running_min_next;
        disp_count <= '0;
      end else begin
        disp_count <= disp_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.path_cost     <= path;
      out_ch.disparity     <= sgm_pca_pkg::DISP_W'(disp_count);
      out_ch.last_of_pixel <= at_highest;
      out_ch.pixel_min     <= at_highest ? running_min_next : '0;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
